// ===== src/prvd_pkg.sv =====
// Package for the posting record varint decoder.
// Payload structs, request and result codes, integer assembly types.
// No dependencies.
`default_nettype none

package prvd_pkg;

  localparam int unsigned MaxIntBytes = 5;
  localparam int unsigned CntW        = $clog2(MaxIntBytes + 1);
  localparam int unsigned ShamtW      = CntW + 3;

  localparam logic ReqData  = 1'b0;
  localparam logic ReqReset = 1'b1;

  localparam logic KindHeader = 1'b0;
  localparam logic KindPos    = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  in_byte;
    logic [31:0] start_doc;
  } req_t;

  typedef struct packed {
    logic        item_kind;
    logic [31:0] doc_number;
    logic [31:0] term_freq;
    logic [7:0]  norm_byte;
    logic [31:0] position;
    logic        last_of_record;
    logic        vint_overflow;
  } rsp_t;

  typedef enum logic [1:0] {
    VintMore,
    VintDone,
    VintOvf
  } vint_status_e;

  typedef struct packed {
    vint_status_e     status;
    logic [31:0]      accum;
    logic [CntW-1:0]  count;
  } vint_res_t;

endpackage

`default_nettype wire

// ===== src/prvd_in_stage.sv =====
// Input register stage: holds one request until the parser takes it.
// Depends on prvd_pkg.
`default_nettype none

module prvd_in_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire prvd_pkg::req_t in_data_i,
  output logic               req_valid_o,
  output prvd_pkg::req_t     req_data_o,
  input  wire logic          req_take_i
);

  logic           valid_q, valid_d;
  prvd_pkg::req_t data_q;
  logic           load;

  assign in_ready_o  = !valid_q || req_take_i;
  assign load        = in_valid_i && in_ready_o;
  assign valid_d     = load || (valid_q && !req_take_i);
  assign req_valid_o = valid_q;
  assign req_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= in_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/prvd_vint_unit.sv =====
// Varint assembly step: merges one stream byte into the partial integer.
// Depends on prvd_pkg.
`default_nettype none

module prvd_vint_unit (
  input  wire logic [31:0]              accum_i,
  input  wire logic [prvd_pkg::CntW-1:0] count_i,
  input  wire logic [7:0]               byte_i,
  output prvd_pkg::vint_res_t           res_o
);

  logic [prvd_pkg::ShamtW-1:0] shamt;
  logic [prvd_pkg::CntW-1:0]   count_next;

  assign shamt      = prvd_pkg::ShamtW'(count_i) * prvd_pkg::ShamtW'(7);
  assign count_next = count_i + prvd_pkg::CntW'(1);

  always_comb begin
    res_o.accum = accum_i | (32'(byte_i[6:0]) << shamt);
    res_o.count = count_next;
    if (!byte_i[7]) begin
      res_o.status = prvd_pkg::VintDone;
    end else if (count_next >= prvd_pkg::CntW'(prvd_pkg::MaxIntBytes)) begin
      res_o.status = prvd_pkg::VintOvf;
    end else begin
      res_o.status = prvd_pkg::VintMore;
    end
  end

endmodule

`default_nettype wire

// ===== src/prvd_parser.sv =====
// Record parser: phase, running sums and the result register.
// Depends on prvd_pkg and prvd_vint_unit.
`default_nettype none

module prvd_parser (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           req_valid_i,
  input  wire prvd_pkg::req_t req_data_i,
  output logic                req_take_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output prvd_pkg::rsp_t      out_data_o
);

  typedef enum logic [1:0] {
    PhDoc,
    PhFreq,
    PhNorm,
    PhPos
  } phase_e;

  phase_e                     phase_q, phase_d;
  logic [31:0]                accum_q, accum_d;
  logic [prvd_pkg::CntW-1:0]  count_q, count_d;
  logic [31:0]                doc_q, doc_d;
  logic [31:0]                freq_q, freq_d;
  logic [31:0]                left_q, left_d;
  logic [31:0]                pos_q, pos_d;
  logic [7:0]                 norm_q, norm_d;
  logic                       out_valid_q, out_valid_d;
  prvd_pkg::rsp_t             out_q, rsp;
  logic                       emit;
  logic [31:0]                left_dec;
  logic [31:0]                pos_sum;
  prvd_pkg::vint_res_t        vr;

  prvd_vint_unit u_vint (
    .accum_i (accum_q),
    .count_i (count_q),
    .byte_i  (req_data_i.in_byte),
    .res_o   (vr)
  );

  assign req_take_o = req_valid_i && (!out_valid_q || out_ready_i);
  assign left_dec   = (left_q != 32'd0) ? left_q - 32'd1 : 32'd0;
  assign pos_sum    = pos_q + vr.accum;

  always_comb begin
    phase_d = phase_q;
    accum_d = accum_q;
    count_d = count_q;
    doc_d   = doc_q;
    freq_d  = freq_q;
    left_d  = left_q;
    pos_d   = pos_q;
    norm_d  = norm_q;
    emit    = 1'b0;
    rsp     = '0;
    rsp.doc_number = doc_q;
    if (req_data_i.req_type == prvd_pkg::ReqReset) begin
      phase_d = PhDoc;
      accum_d = '0;
      count_d = '0;
      freq_d  = '0;
      left_d  = '0;
      pos_d   = '0;
      norm_d  = '0;
      doc_d   = req_data_i.start_doc;
    end else if (phase_q == PhNorm) begin
      norm_d  = req_data_i.in_byte;
      left_d  = freq_q;
      pos_d   = '0;
      phase_d = (freq_q == 32'd0) ? PhDoc : PhPos;
      emit    = 1'b1;
      rsp.item_kind      = prvd_pkg::KindHeader;
      rsp.term_freq      = freq_q;
      rsp.norm_byte      = req_data_i.in_byte;
      rsp.last_of_record = (freq_q == 32'd0);
    end else begin
      case (vr.status)
        prvd_pkg::VintMore: begin
          accum_d = vr.accum;
          count_d = vr.count;
        end
        prvd_pkg::VintOvf: begin
          phase_d = PhDoc;
          accum_d = '0;
          count_d = '0;
          freq_d  = '0;
          left_d  = '0;
          pos_d   = '0;
          norm_d  = '0;
          emit    = 1'b1;
          rsp.item_kind      = prvd_pkg::KindHeader;
          rsp.last_of_record = 1'b1;
          rsp.vint_overflow  = 1'b1;
        end
        default: begin
          accum_d = '0;
          count_d = '0;
          unique case (phase_q)
            PhDoc: begin
              doc_d = doc_q + {1'b0, vr.accum[31:1]};
              if (vr.accum[0]) begin
                freq_d  = 32'd1;
                phase_d = PhNorm;
              end else begin
                phase_d = PhFreq;
              end
            end
            PhFreq: begin
              freq_d  = vr.accum;
              phase_d = PhNorm;
            end
            default: begin
              pos_d  = pos_sum;
              left_d = left_dec;
              if (left_dec == 32'd0) begin
                phase_d = PhDoc;
              end
              emit = 1'b1;
              rsp.item_kind      = prvd_pkg::KindPos;
              rsp.term_freq      = freq_q;
              rsp.norm_byte      = norm_q;
              rsp.position       = pos_sum;
              rsp.last_of_record = (left_dec == 32'd0);
            end
          endcase
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (req_take_o && emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhDoc;
      accum_q     <= '0;
      count_q     <= '0;
      doc_q       <= '0;
      freq_q      <= '0;
      left_q      <= '0;
      pos_q       <= '0;
      norm_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (req_take_o) begin
        phase_q <= phase_d;
        accum_q <= accum_d;
        count_q <= count_d;
        doc_q   <= doc_d;
        freq_q  <= freq_d;
        left_q  <= left_d;
        pos_q   <= pos_d;
        norm_q  <= norm_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_take_o && emit) begin
      out_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== src/posting_record_vint_decoder_top.sv =====
// Top level of the posting record varint decoder.
// Depends on prvd_pkg, prvd_in_stage, prvd_parser.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o   in_data_i  (prvd_pkg::req_t)
//   out      output     out_valid_o / out_ready_i out_data_o (prvd_pkg::rsp_t)
//
// One byte per cycle while the result register is empty or being drained: a request
// goes input register -> parser -> result register.
// The parser moves on whenever the result register is empty or being drained.
// At most one result per request; requests that yield none update only the parser state.
// rst_ni clears control and running state; a reset request reloads the doc number.
`default_nettype none

module posting_record_vint_decoder_top (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire prvd_pkg::req_t in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output prvd_pkg::rsp_t      out_data_o
);

  logic           req_valid;
  logic           req_take;
  prvd_pkg::req_t req_data;

  prvd_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .req_valid_o (req_valid),
    .req_data_o  (req_data),
    .req_take_i  (req_take)
  );

  prvd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_data_i  (req_data),
    .req_take_o  (req_take),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
